/* design/sorted_insert_max_queue_macros.svh */
// Assertion macros for the sorted insert max queue.
// Defining NO_ASSERTIONS turns every use into nothing; no other dependencies.
`ifndef SORTED_INSERT_MAX_QUEUE_MACROS_SVH
`define SORTED_INSERT_MAX_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SQM_ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SQM_ASSERT(lbl, prop, msg) \
   `SQM_ASSERT_AT(lbl, clock, reset, prop, msg)
`else
`define SQM_ASSERT_AT(lbl, clk, rst, prop, msg)
`define SQM_ASSERT(lbl, prop, msg)
`endif

`endif

/* design/sqm_pkg.sv */
// Shared types and constants for the sorted insert max queue.
// No dependencies; used by the channel interfaces, the cell and the top level.
`default_nettype none

package sqm_pkg;

   localparam int CAPACITY          = 16;
   localparam int VALUE_WIDTH       = 32;
   localparam int COUNT_WIDTH       = $clog2(CAPACITY + 1);
   localparam int KIND_WIDTH        = 2;
   localparam int ENTRY_COUNT_WIDTH = 5;
   localparam int STATUS_WIDTH      = 2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      value_type             value;
   } req_payload_type;

   typedef struct packed {
      value_type                    popped_value;
      logic                         found;
      logic                         empty_res;
      logic [ENTRY_COUNT_WIDTH-1:0] entry_count;
      logic [STATUS_WIDTH-1:0]      status;
   } rsp_payload_type;

   // Command broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic      push_en;
      logic      pop_en;
      value_type value;
   } cell_cmd_type;

endpackage

`default_nettype wire

/* design/sqm_channel_if.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on sqm_pkg for the payload types.
`default_nettype none

interface sqm_req_if;
   logic                     valid;
   logic                     ready;
   sqm_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sqm_rsp_if;
   logic                     valid;
   logic                     ready;
   sqm_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/sqm_cell.sv */
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on sqm_pkg for the value and command types.
`default_nettype none

module sqm_cell (
   input  wire logic                  clock,
   input  wire sqm_pkg::cell_cmd_type cmd,
   input  wire logic                  occupied,
   input  wire logic                  above_ge,
   input  wire sqm_pkg::value_type    above_entry,
   input  wire sqm_pkg::value_type    below_entry,
   output sqm_pkg::value_type         entry,
   output logic                       ge,
   output logic                       hit
);

   sqm_pkg::value_type entry_ff;
   sqm_pkg::value_type entry_in;

   // The new value belongs at or above this slot when the slot is free or
   // holds a value that is not larger; equal entries therefore move down.
   assign ge  = !occupied || (cmd.value >= entry_ff);
   assign hit = occupied && (cmd.value == entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push_en && ge) begin
         entry_in = above_ge ? above_entry : cmd.value;
      end else if (cmd.pop_en) begin
         entry_in = below_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

/* design/sorted_insert_max_queue.sv */
// Top level of the sorted insert max queue: a chain of sorting cells,
// the entry count and the response register. Depends on sqm_pkg,
// sqm_channel_if, sqm_cell and the assertion macro header.
//
//   port    dir   carries
//   req_ch  sink  kind and value of one push, pop or query item
//   rsp_ch  src   popped value, found, empty flag, entry count, status
//
// One item is taken per cycle; its result appears in the response register
// on the next cycle. Every cell compares the item value with its entry in
// the same cycle and shifts in a neighbor's entry, so the chain updates in
// one step. A stalled response holds req_ch.ready low until it is taken.
// Reset clears the entry count and the response valid; entries are not reset.
`default_nettype none

`include "sorted_insert_max_queue_macros.svh"

module sorted_insert_max_queue (
   input  wire logic clock,
   input  wire logic reset,
   sqm_req_if.sink   req_ch,
   sqm_rsp_if.source rsp_ch
);

   localparam int N = sqm_pkg::CAPACITY;

   sqm_pkg::count_type       count_ff;
   sqm_pkg::count_type       count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   sqm_pkg::rsp_payload_type rsp_payload_ff;
   sqm_pkg::rsp_payload_type rsp_payload_in;

   logic                     accept;
   logic                     push_ok;
   logic                     pop_ok;
   sqm_pkg::cell_cmd_type    cmd;
   sqm_pkg::value_type       entry_vec [N];
   logic [N-1:0]             ge_vec;
   logic [N-1:0]             hit_vec;
   logic [N-1:0]             occupied_vec;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign push_ok = (req_ch.payload.kind == sqm_pkg::KIND_PUSH)
                    && (count_ff != sqm_pkg::count_type'(N));
   assign pop_ok  = (req_ch.payload.kind == sqm_pkg::KIND_POP)
                    && (count_ff != '0);

   assign cmd.push_en = accept && push_ok;
   assign cmd.pop_en  = accept && pop_ok;
   assign cmd.value   = req_ch.payload.value;

   // Slot 0 holds the largest entry; slots at or beyond the count are free.
   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occupied_vec[i] = sqm_pkg::count_type'(i) < count_ff;

      sqm_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied_vec[i]),
         .above_ge    ((i == 0) ? 1'b0 : ge_vec[(i == 0) ? 0 : i - 1]),
         .above_entry (entry_vec[(i == 0) ? 0 : i - 1]),
         .below_entry (entry_vec[(i == N - 1) ? N - 1 : i + 1]),
         .entry       (entry_vec[i]),
         .ge          (ge_vec[i]),
         .hit         (hit_vec[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.popped_value = '0;
         rsp_payload_in.found        = 1'b0;
         rsp_payload_in.status       = sqm_pkg::STATUS_OK;
         case (req_ch.payload.kind)
            sqm_pkg::KIND_PUSH: begin
               if (push_ok) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  rsp_payload_in.status = sqm_pkg::STATUS_FULL;
               end
            end
            sqm_pkg::KIND_POP: begin
               if (pop_ok) begin
                  count_in                    = count_ff - 1'b1;
                  rsp_payload_in.popped_value = entry_vec[0];
               end else begin
                  rsp_payload_in.status = sqm_pkg::STATUS_EMPTY;
               end
            end
            sqm_pkg::KIND_QUERY: begin
               rsp_payload_in.found = |hit_vec;
            end
            default: begin
            end
         endcase
         rsp_payload_in.empty_res   = (count_in == '0);
         rsp_payload_in.entry_count =
            sqm_pkg::ENTRY_COUNT_WIDTH'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   `SQM_ASSERT(a_count_bound, count_ff <= sqm_pkg::count_type'(N), "count above capacity")
   `SQM_ASSERT(a_accept_rsp, accept |=> rsp_ch.valid, "accepted item gave no result")
   `SQM_ASSERT(a_stall_block, rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready, "took item while stalled")
   `SQM_ASSERT(a_pop_count, cmd.pop_en |=> count_ff == $past(count_ff) - 1'b1, "pop did not decrement")

endmodule

`default_nettype wire
